FILE: rtl/core/ned_pkg.sv
// ----------------------------------------------------------------------------
// ned_pkg
// Shared constants, types and character helpers of the name escape decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ned_pkg;

  // String buffer depth and the widths that follow from it
  localparam int MAX_LEN = 48;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  // Length and read pointer: the pointer runs up to three past the string
  localparam int LEN_W   = $clog2(MAX_LEN + 4);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UH    = 8'h48;
  localparam logic [7:0] CH_UN    = 8'h4E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PREP,
    ST_FILL0,
    ST_FILL1,
    ST_FILL2,
    ST_RUN,
    ST_ADV2,
    ST_ADV1,
    ST_SKIP,
    ST_SCAN,
    ST_EXP_A,
    ST_EXP_OPEN,
    ST_EXP_BODY,
    ST_COPY,
    ST_DONE
  } ned_state_t;

  // How far the window moves after a decoded byte
  typedef enum logic [1:0] {
    STEP_ONE,
    STEP_TWO,
    STEP_THREE
  } ned_step_t;

  // Outcome of one look-ahead step over a subtype tag
  typedef enum logic [1:0] {
    SCAN_MORE,
    SCAN_HIT,
    SCAN_MISS
  } ned_scan_t;

  // Source of the byte loaded into the output register
  typedef enum logic [2:0] {
    EM_COPY,
    EM_RUN,
    EM_A,
    EM_OPEN,
    EM_BODY,
    EM_CLOSE
  } ned_emit_t;

  typedef struct packed {
    logic      take;
    logic      start;
    logic      shift;
    logic      emit;
    ned_emit_t sel;
    logic      scan_begin;
    logic      scan_eval;
    logic      rewind;
    logic      clear;
  } ned_cmd_t;

  typedef struct packed {
    logic      got_last;
    logic      decode;
    logic      out_free;
    logic      more_dec;
    logic      more_copy;
    logic      cand;
    ned_step_t step;
    ned_scan_t scan;
    logic      exp_go;
    logic      at_close;
  } ned_stat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      t = c - 8'h57;
    end else if (c inside {[8'h41:8'h46]}) begin
      t = c - 8'h37;
    end else begin
      t = 8'h00;
    end
    return t[3:0];
  endfunction

endpackage

FILE: rtl/core/ned_in_if.sv
// ----------------------------------------------------------------------------
// ned_in_if
// Encoded byte stream: one string byte per transaction, last marks the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ned_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_in;

  modport source (output valid, output byte_in, output last_in, input ready);
  modport sink   (input valid, input byte_in, input last_in, output ready);
endinterface

FILE: rtl/core/ned_out_if.sv
// ----------------------------------------------------------------------------
// ned_out_if
// Decoded byte stream: one name byte per transaction with end and overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ned_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       last_out;
  logic       overflow;

  modport source (output valid, output byte_out, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input byte_out, input last_out, input overflow,
                  output ready);
endinterface

FILE: rtl/core/ned_ram.sv
// ----------------------------------------------------------------------------
// ned_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ned_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/ned_ctrl.sv
// ----------------------------------------------------------------------------
// ned_ctrl
// Sequencer: load the string, walk the buffer and direct each output byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ned_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  ned_pkg::ned_stat_t  stat,
  output ned_pkg::ned_cmd_t   cmd
);

  ned_pkg::ned_state_t state;
  ned_pkg::ned_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ned_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ned_pkg::ST_LOAD: begin
        if (stat.got_last) state_next = ned_pkg::ST_PREP;
      end
      ned_pkg::ST_PREP:  state_next = ned_pkg::ST_FILL0;
      ned_pkg::ST_FILL0: state_next = ned_pkg::ST_FILL1;
      ned_pkg::ST_FILL1: state_next = ned_pkg::ST_FILL2;
      ned_pkg::ST_FILL2: begin
        if (!stat.decode) begin
          state_next = ned_pkg::ST_COPY;
        end else if (stat.exp_go) begin
          state_next = ned_pkg::ST_EXP_A;
        end else begin
          state_next = ned_pkg::ST_RUN;
        end
      end
      ned_pkg::ST_RUN: begin
        if (!stat.more_dec) begin
          state_next = ned_pkg::ST_DONE;
        end else if (stat.cand) begin
          state_next = ned_pkg::ST_SKIP;
        end else if (stat.out_free) begin
          case (stat.step)
            ned_pkg::STEP_TWO:   state_next = ned_pkg::ST_ADV1;
            ned_pkg::STEP_THREE: state_next = ned_pkg::ST_ADV2;
            default:             state_next = ned_pkg::ST_RUN;
          endcase
        end
      end
      ned_pkg::ST_ADV2: state_next = ned_pkg::ST_ADV1;
      ned_pkg::ST_ADV1: state_next = ned_pkg::ST_RUN;
      ned_pkg::ST_SKIP: state_next = ned_pkg::ST_SCAN;
      ned_pkg::ST_SCAN: begin
        if (stat.scan != ned_pkg::SCAN_MORE) state_next = ned_pkg::ST_FILL0;
      end
      ned_pkg::ST_EXP_A: begin
        if (stat.out_free) state_next = ned_pkg::ST_EXP_OPEN;
      end
      ned_pkg::ST_EXP_OPEN: begin
        if (stat.out_free) state_next = ned_pkg::ST_EXP_BODY;
      end
      ned_pkg::ST_EXP_BODY: begin
        if (stat.out_free && stat.at_close) state_next = ned_pkg::ST_RUN;
      end
      ned_pkg::ST_COPY: begin
        if (!stat.more_copy) state_next = ned_pkg::ST_DONE;
      end
      ned_pkg::ST_DONE: state_next = ned_pkg::ST_LOAD;
      default:          state_next = ned_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd     = '0;
    cmd.sel = ned_pkg::EM_COPY;
    case (state)
      ned_pkg::ST_LOAD: cmd.take  = 1'b1;
      ned_pkg::ST_PREP: cmd.start = 1'b1;
      ned_pkg::ST_FILL0,
      ned_pkg::ST_FILL1,
      ned_pkg::ST_FILL2,
      ned_pkg::ST_ADV2,
      ned_pkg::ST_ADV1,
      ned_pkg::ST_SKIP: cmd.shift = 1'b1;
      ned_pkg::ST_RUN: begin
        if (stat.more_dec) begin
          if (stat.cand) begin
            cmd.scan_begin = 1'b1;
            cmd.shift      = 1'b1;
          end else if (stat.out_free) begin
            cmd.emit  = 1'b1;
            cmd.sel   = ned_pkg::EM_RUN;
            cmd.shift = 1'b1;
          end
        end
      end
      ned_pkg::ST_SCAN: begin
        cmd.scan_eval = 1'b1;
        if (stat.scan == ned_pkg::SCAN_MORE) begin
          cmd.shift = 1'b1;
        end else begin
          cmd.rewind = 1'b1;
        end
      end
      ned_pkg::ST_EXP_A: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = ned_pkg::EM_A;
          cmd.shift = 1'b1;
        end
      end
      ned_pkg::ST_EXP_OPEN: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = ned_pkg::EM_OPEN;
        end
      end
      ned_pkg::ST_EXP_BODY: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = stat.at_close ? ned_pkg::EM_CLOSE : ned_pkg::EM_BODY;
          cmd.shift = !stat.at_close;
        end
      end
      ned_pkg::ST_COPY: begin
        if (stat.more_copy && stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = ned_pkg::EM_COPY;
          cmd.shift = 1'b1;
        end
      end
      ned_pkg::ST_DONE: cmd.clear = 1'b1;
      default: cmd.take = 1'b0;
    endcase
  end

endmodule

FILE: rtl/core/ned_datapath.sv
// ----------------------------------------------------------------------------
// ned_datapath
// String buffer, three-byte read window, decode logic and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ned_datapath (
  input  logic               clk,
  input  logic               rst,
  input  ned_pkg::ned_cmd_t  cmd,
  output ned_pkg::ned_stat_t stat,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic               out_ovf
);

  localparam int LW = ned_pkg::LEN_W;

  // Load-side state
  logic [LW-1:0] wr_len;
  logic          ovf_seen;
  logic          brk_seen;
  logic [LW-1:0] last_brk;
  logic [7:0]    sig_hi;
  logic [7:0]    sig_lo;

  // Pass state
  logic          decode;
  logic          after_space;
  logic          force_copy;
  logic          exp_go;
  logic [LW-1:0] rd_ptr;
  logic [LW-1:0] rd_ptr_next;
  logic [7:0]    rdata;
  logic [7:0]    w0;
  logic [7:0]    w1;
  logic [7:0]    w2;
  logic [LW-1:0] mark;
  logic [LW-1:0] sc_end;
  logic          sc_phase;
  logic          seen1;
  logic          seen2;

  // Output register
  logic          ob_valid;
  logic [7:0]    ob_byte;
  logic          ob_last;
  logic          ob_ovf;

  logic          accept;
  logic          store;
  logic          has_sig;
  logic [LW-1:0] pos;
  logic [LW:0]   ptr_x;
  logic [LW:0]   lim_x;
  logic          v0, v1, v2, v3, v4, v5;
  logic [7:0]    dec_byte;
  ned_pkg::ned_step_t dec_step;
  logic          dec_last;
  ned_pkg::ned_scan_t scan;
  logic          sc_dig;
  logic          sc_n;
  logic [7:0]    em_byte;
  logic          em_last;
  logic          em_ovf;

  assign accept = cmd.take && in_valid;
  assign store  = accept && (wr_len < LW'(ned_pkg::MAX_LEN));

  ned_ram #(
    .WIDTH (8),
    .DEPTH (ned_pkg::MAX_LEN)
  ) u_buf (
    .clk   (clk),
    .we    (store),
    .waddr (wr_len[ned_pkg::ADDR_W-1:0]),
    .wdata (in_byte),
    .raddr (rd_ptr_next[ned_pkg::ADDR_W-1:0]),
    .rdata (rdata)
  );

  // Read address runs one step ahead so rdata always holds buf[rd_ptr]
  always_comb begin
    if (cmd.start) begin
      rd_ptr_next = '0;
    end else if (cmd.rewind) begin
      rd_ptr_next = mark;
    end else if (cmd.shift) begin
      rd_ptr_next = rd_ptr + LW'(1);
    end else begin
      rd_ptr_next = rd_ptr;
    end
  end

  // With a full window, w0 sits at pos and the pointer three bytes ahead
  assign pos   = rd_ptr - LW'(3);
  assign ptr_x = {1'b0, rd_ptr};
  assign lim_x = {1'b0, wr_len} + (LW+1)'(3);
  assign v0    = ptr_x < lim_x;
  assign v1    = (ptr_x + (LW+1)'(1)) < lim_x;
  assign v2    = (ptr_x + (LW+1)'(2)) < lim_x;
  assign v3    = (ptr_x + (LW+1)'(3)) < lim_x;
  assign v4    = (ptr_x + (LW+1)'(4)) < lim_x;
  assign v5    = (ptr_x + (LW+1)'(5)) < lim_x;

  always_comb begin
    has_sig = 1'b0;
    if (wr_len > LW'(2)) begin
      case (sig_hi)
        ned_pkg::CH_BANG:  has_sig = (sig_lo == ned_pkg::CH_LB) || (sig_lo == ned_pkg::CH_UB);
        ned_pkg::CH_SLASH: has_sig = (sig_lo == ned_pkg::CH_LA) || (sig_lo == ned_pkg::CH_UA);
        ned_pkg::CH_AT:    has_sig = (sig_lo == ned_pkg::CH_LA) || (sig_lo == ned_pkg::CH_UA)
                                  || (sig_lo == ned_pkg::CH_LB) || (sig_lo == ned_pkg::CH_UB);
        default:           has_sig = 1'b0;
      endcase
    end
  end

  // One decode step at pos
  always_comb begin
    dec_byte = w0;
    dec_step = ned_pkg::STEP_ONE;
    if (force_copy) begin
      dec_byte = w0;
    end else if (w0 == ned_pkg::CH_DOT && v1 && w1 == ned_pkg::CH_DOT) begin
      dec_byte = ned_pkg::CH_COMMA;
      dec_step = ned_pkg::STEP_TWO;
    end else if (w0 == ned_pkg::CH_UNDER) begin
      dec_byte = ned_pkg::CH_SPACE;
    end else if (w0 == ned_pkg::CH_PCT && v2 && ned_pkg::is_hex(w1)
                 && ned_pkg::is_hex(w2)) begin
      dec_byte = {ned_pkg::hex_val(w1), ned_pkg::hex_val(w2)};
      dec_step = ned_pkg::STEP_THREE;
    end
  end

  always_comb begin
    case (dec_step)
      ned_pkg::STEP_TWO:   dec_last = !v4;
      ned_pkg::STEP_THREE: dec_last = !v5;
      default:             dec_last = !v3;
    endcase
  end

  // Subtype look-ahead: digits, N, digits, then no line break to the end
  assign sc_dig = v0 && ned_pkg::is_digit(w0);
  assign sc_n   = v0 && (w0 == ned_pkg::CH_UN);

  always_comb begin
    if (!sc_phase) begin
      scan = (sc_dig || (seen1 && sc_n)) ? ned_pkg::SCAN_MORE : ned_pkg::SCAN_MISS;
    end else if (sc_dig) begin
      scan = ned_pkg::SCAN_MORE;
    end else if (seen2 && !(brk_seen && last_brk >= pos)) begin
      scan = ned_pkg::SCAN_HIT;
    end else begin
      scan = ned_pkg::SCAN_MISS;
    end
  end

  always_comb begin
    em_byte = w0;
    em_last = 1'b0;
    em_ovf  = 1'b0;
    case (cmd.sel)
      ned_pkg::EM_COPY: begin
        em_last = !v1;
        em_ovf  = ovf_seen;
      end
      ned_pkg::EM_RUN: begin
        em_byte = dec_byte;
        em_last = dec_last;
      end
      ned_pkg::EM_A:     em_byte = ned_pkg::CH_UA;
      ned_pkg::EM_OPEN:  em_byte = ned_pkg::CH_OPEN;
      ned_pkg::EM_BODY:  em_byte = w0;
      ned_pkg::EM_CLOSE: begin
        em_byte = ned_pkg::CH_CLOSE;
        em_last = !v2;
      end
      default: em_byte = w0;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_len      <= '0;
      ovf_seen    <= 1'b0;
      brk_seen    <= 1'b0;
      decode      <= 1'b0;
      after_space <= 1'b1;
      force_copy  <= 1'b0;
      exp_go      <= 1'b0;
      sc_phase    <= 1'b0;
      seen1       <= 1'b0;
      seen2       <= 1'b0;
      ob_valid    <= 1'b0;
    end else begin
      if (store) begin
        wr_len <= wr_len + LW'(1);
        if (in_byte == ned_pkg::CH_LF || in_byte == ned_pkg::CH_CR) brk_seen <= 1'b1;
      end else if (accept) begin
        ovf_seen <= 1'b1;
      end
      if (cmd.clear) begin
        wr_len   <= '0;
        ovf_seen <= 1'b0;
        brk_seen <= 1'b0;
      end
      if (cmd.start) begin
        decode      <= !ovf_seen && has_sig;
        after_space <= 1'b1;
        force_copy  <= 1'b0;
        exp_go      <= 1'b0;
      end
      if (cmd.scan_begin) begin
        sc_phase <= 1'b0;
        seen1    <= 1'b0;
        seen2    <= 1'b0;
      end
      if (cmd.scan_eval) begin
        if (!sc_phase) begin
          if (sc_dig) begin
            seen1 <= 1'b1;
          end else if (seen1 && sc_n) begin
            sc_phase <= 1'b1;
          end
        end else if (sc_dig) begin
          seen2 <= 1'b1;
        end
        if (scan == ned_pkg::SCAN_HIT)  exp_go     <= 1'b1;
        if (scan == ned_pkg::SCAN_MISS) force_copy <= 1'b1;
      end
      if (cmd.emit) begin
        if (cmd.sel == ned_pkg::EM_RUN) begin
          after_space <= (dec_byte == ned_pkg::CH_SPACE);
          force_copy  <= 1'b0;
        end
        if (cmd.sel == ned_pkg::EM_CLOSE) after_space <= 1'b0;
        if (cmd.sel == ned_pkg::EM_A)     exp_go      <= 1'b0;
      end
      if (cmd.emit) begin
        ob_valid <= 1'b1;
      end else if (out_ready) begin
        ob_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_ptr <= rd_ptr_next;
    if (store) begin
      sig_hi <= sig_lo;
      sig_lo <= in_byte;
      if (in_byte == ned_pkg::CH_LF || in_byte == ned_pkg::CH_CR) last_brk <= wr_len;
    end
    if (cmd.shift) begin
      w0 <= w1;
      w1 <= w2;
      w2 <= rdata;
    end
    if (cmd.scan_begin) mark <= pos;
    if (cmd.scan_eval && scan == ned_pkg::SCAN_HIT) sc_end <= pos;
    if (cmd.emit) begin
      ob_byte <= em_byte;
      ob_last <= em_last;
      ob_ovf  <= em_ovf;
    end
  end

  assign stat.got_last  = accept && in_last;
  assign stat.decode    = decode;
  assign stat.out_free  = !ob_valid || out_ready;
  assign stat.more_dec  = v2;
  assign stat.more_copy = v0;
  assign stat.cand      = !force_copy && after_space && v1
                          && (w0 == ned_pkg::CH_UA) && (w1 == ned_pkg::CH_UH);
  assign stat.step      = dec_step;
  assign stat.scan      = scan;
  assign stat.exp_go    = exp_go;
  assign stat.at_close  = (pos == sc_end);

  assign out_valid = ob_valid;
  assign out_byte  = ob_byte;
  assign out_last  = ob_last;
  assign out_ovf   = ob_ovf;

endmodule

FILE: rtl/core/name_escape_decoder.sv
// ----------------------------------------------------------------------------
// name_escape_decoder
// Collects one escaped name string a byte per transaction on enc and sends
// the decoded name a byte per transaction on dec. A string that ends in one
// of the signatures !b !B @b @B /a /A @a @A and is longer than two bytes
// loses the signature and is decoded: ".." gives a comma, "_" a space, "%hh"
// the byte it spells, and an "A" at the start or after a decoded space that
// is followed by H, digits, N and digits becomes "A(H..N..)" unless a line
// break follows the tag anywhere in the string. Any other string is sent
// unchanged. Bytes beyond 48 are dropped; such a string is sent undecoded
// with overflow high on every byte. last_out marks the final byte. enc is
// ready while a string loads and is held off while the buffer is walked.
// The walk opens with the prepare and fill steps that load the read window,
// then passes the string through the single read port of the string buffer
// at one byte per cycle while dec is not stalled; a decoded string skips its
// two signature bytes. A subtype tag is first checked by a look-ahead; if it
// expands, the walk rewinds to its A and refills the window, and a rejected
// tag is re-read likewise with its A sent unchanged. A stalled dec side holds
// the walk. After the last result the walk still passes the rest of the last
// escape and a done step before enc is ready again; that result may still
// wait in the output register while the next string loads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module name_escape_decoder (
  input logic      clk,
  input logic      rst,
  ned_in_if.sink   enc,
  ned_out_if.source dec
);

  // Controller and datapath talk only through these two bundles
  ned_pkg::ned_cmd_t  cmd;
  ned_pkg::ned_stat_t stat;

  // Sequence load, buffer walk, look-ahead and emission
  ned_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // Hold the string, decode from the read window, drive the output register
  ned_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_valid  (enc.valid),
    .in_byte   (enc.byte_in),
    .in_last   (enc.last_in),
    .out_valid (dec.valid),
    .out_ready (dec.ready),
    .out_byte  (dec.byte_out),
    .out_last  (dec.last_out),
    .out_ovf   (dec.overflow)
  );

  // Input is open only while a string is loading
  assign enc.ready = cmd.take;

endmodule

FILE: rtl/core/ned_checker.sv
// ----------------------------------------------------------------------------
// ned_checker
// Port-level checks of the name escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ned_checker (
  input logic       clk,
  input logic       rst,
  input logic       enc_valid,
  input logic       enc_ready,
  input logic       enc_last,
  input logic       dec_valid,
  input logic       dec_ready,
  input logic [7:0] dec_byte,
  input logic       dec_last,
  input logic       dec_ovf
);

  // Reset empties the output register
  a_reset_idle: assert property (@(posedge clk) rst |=> !dec_valid)
    else $error("result offered right after reset");

  // Only the final byte of a string may still wait while a new one loads
  a_load_after_walk: assert property (@(posedge clk) disable iff (rst)
    dec_valid && !dec_last |-> !enc_ready)
    else $error("input open while a string is still being sent");

  // The final byte of a string closes the input for the walk
  a_close_on_last: assert property (@(posedge clk) disable iff (rst)
    enc_valid && enc_ready && enc_last |=> !enc_ready)
    else $error("input still open after the final byte");

  // A stalled result holds
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    dec_valid && !dec_ready |=> dec_valid && $stable(dec_byte)
                                 && $stable(dec_last) && $stable(dec_ovf))
    else $error("stalled result changed");

endmodule

bind name_escape_decoder ned_checker u_ned_checker (
  .clk       (clk),
  .rst       (rst),
  .enc_valid (enc.valid),
  .enc_ready (enc.ready),
  .enc_last  (enc.last_in),
  .dec_valid (dec.valid),
  .dec_ready (dec.ready),
  .dec_byte  (dec.byte_out),
  .dec_last  (dec.last_out),
  .dec_ovf   (dec.overflow)
);
